### rtl/shxfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfr_pkg: shared definitions for the sync-header XOR frame receiver
// Types, codes and constants used by the front end, the command queue
// and the result generator.
// ----------------------------------------------------------------------------
package shxfr_pkg;

  localparam int FRAME_BYTES_DEF = 24;
  localparam int IDX_W           = 6;

  localparam logic [7:0]  HDR_FIRST     = 8'hAA;
  localparam logic [7:0]  HDR_SECOND    = 8'h55;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;
  localparam logic [2:0]  REPLY_LAST    = 3'd6;

  // Input item kinds carried in tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_REPLY    = 2'd1,
    KIND_MISMATCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_PAY   = 2'd1,
    BK_REPLY = 2'd2
  } back_state_t;

  // One finished frame handed from the front end to the result generator.
  typedef struct packed {
    logic        good;
    logic [31:0] yaw;
  } cmd_t;

  // Payload buffer write from the front end.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } pl_wr_t;

  function automatic logic [7:0] reply_byte(input logic [31:0] yaw, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0: b = HDR_SECOND;
      3'd1: b = HDR_FIRST;
      3'd2: b = yaw[7:0];
      3'd3: b = yaw[15:8];
      3'd4: b = yaw[23:16];
      3'd5: b = yaw[31:24];
      3'd6: b = yaw[7:0] ^ yaw[15:8] ^ yaw[23:16] ^ yaw[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/sync_header_xor_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_xor_frame_receiver_core: framed byte receiver with reply
// Hunts for 0xAA 0x55 headers, checks the XOR byte and emits payload and
// reply bytes, or a mismatch status.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one received byte (tuser low) or one millisecond
// tick (tuser high) per transaction, together with the current yaw word.
// The front end takes one transaction per cycle while s_tready is high.
// A completed frame becomes a command in a two-entry queue; the back end
// then drives the output stream through a registered stage, one result
// per cycle while the receiver is ready.
// A good frame gives FRAME_BYTES payload results and seven reply results;
// a bad check byte gives one mismatch result. The first result of a good
// frame passes through the queue, the payload state and the output
// register; a mismatch result goes from the queue into the output register.
// The payload buffer has a single write port shared with the next frame,
// so payload bytes of a new frame are held off (s_tready low) until the
// back end is idle with an empty queue; header bytes still flow, but ticks
// in the data phase wait as well. When the receiver stalls, the output
// transaction is held and the back end waits.
// Reset returns the hunt to the first header, clears the silence count,
// sets the timeout to 50 ticks and empties the queue and output stage.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module sync_header_xor_frame_receiver_core #(
  parameter int FRAME_BYTES = shxfr_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] yaw_bits
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data, [13:8] position, [15:14] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic              back_busy;
  logic              q_full, q_empty, q_push, q_pop;
  shxfr_pkg::cmd_t   q_cmd, q_head;
  shxfr_pkg::pl_wr_t pl_wr;

  shxfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .pl_wr     (pl_wr)
  );

  shxfr_cmd_q u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  shxfr_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pl_wr    (pl_wr),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### rtl/shxfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfr_front: header hunt, payload capture and silence timeout
// Accepts received bytes and ticks, writes payload bytes into the buffer
// and queues one command per completed frame.
// ----------------------------------------------------------------------------
module shxfr_front #(
  parameter int FRAME_BYTES = shxfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 back_busy,
  input  logic                 q_full,
  output logic                 q_push,
  output shxfr_pkg::cmd_t      q_cmd,
  output shxfr_pkg::pl_wr_t    pl_wr
);

  localparam logic [shxfr_pkg::IDX_W-1:0] FB = shxfr_pkg::IDX_W'(FRAME_BYTES);

  shxfr_pkg::phase_t             phase, phase_next;
  logic [shxfr_pkg::IDX_W-1:0]   byte_index, byte_index_next;
  logic [7:0]                    running_xor, running_xor_next;
  logic [15:0]                   silence, silence_next;
  logic [15:0]                   timeout;
  logic [15:0]                   silence_inc;
  logic                          accept;
  logic [7:0]                    rx_byte;
  logic [31:0]                   yaw_bits;

  assign rx_byte  = s_tdata[7:0];
  assign yaw_bits = s_tdata[39:8];

  // Data-phase bytes and ticks wait while the back end is busy.
  assign s_tready  = !q_full && !(phase == shxfr_pkg::PH_DATA && back_busy);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign silence_inc = (silence == shxfr_pkg::SILENCE_MAX) ? silence : silence + 16'd1;

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_xor_next = running_xor;
    silence_next     = silence;
    q_push           = 1'b0;
    q_cmd.good       = (rx_byte == running_xor);
    q_cmd.yaw        = yaw_bits;
    pl_wr.en         = 1'b0;
    pl_wr.idx        = byte_index;
    pl_wr.data       = rx_byte;
    if (accept) begin
      if (s_tuser == shxfr_pkg::OP_TICK) begin
        silence_next = silence_inc;
        if (phase != shxfr_pkg::PH_HUNT1 && silence_inc > timeout) begin
          phase_next      = shxfr_pkg::PH_HUNT1;
          byte_index_next = '0;
        end
      end else begin
        silence_next = '0;
        case (phase)
          shxfr_pkg::PH_HUNT1: begin
            if (rx_byte == shxfr_pkg::HDR_FIRST) phase_next = shxfr_pkg::PH_HUNT2;
          end
          shxfr_pkg::PH_HUNT2: begin
            byte_index_next = '0;
            if (rx_byte == shxfr_pkg::HDR_SECOND) begin
              phase_next       = shxfr_pkg::PH_DATA;
              running_xor_next = '0;
            end else begin
              phase_next = shxfr_pkg::PH_HUNT1;
            end
          end
          shxfr_pkg::PH_DATA: begin
            running_xor_next = running_xor ^ rx_byte;
            pl_wr.en         = (byte_index < FB);
            byte_index_next  = byte_index + 1'b1;
            if (byte_index_next >= FB) phase_next = shxfr_pkg::PH_CHECK;
          end
          default: begin
            q_push          = 1'b1;
            phase_next      = shxfr_pkg::PH_HUNT1;
            byte_index_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= shxfr_pkg::PH_HUNT1;
      byte_index  <= '0;
      running_xor <= '0;
      silence     <= '0;
      timeout     <= shxfr_pkg::TIMEOUT_RESET;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_xor <= running_xor_next;
      silence     <= silence_next;
      if (cfg_valid && cfg_ready) timeout <= cfg_data;
    end
  end

endmodule

### rtl/shxfr_cmd_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfr_cmd_q: two-entry frame command queue
// Decouples the front end from the result generator.
// ----------------------------------------------------------------------------
module shxfr_cmd_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  shxfr_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output shxfr_pkg::cmd_t  head,
  output logic             empty,
  output logic             full
);

  shxfr_pkg::cmd_t entries [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

### rtl/shxfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shxfr_back: payload buffer and result generator
// Holds the payload buffer and, per queued command, emits the payload and
// reply bytes or a mismatch status through a registered output stage.
// ----------------------------------------------------------------------------
module shxfr_back #(
  parameter int FRAME_BYTES = shxfr_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  shxfr_pkg::pl_wr_t  pl_wr,
  input  logic               q_empty,
  input  shxfr_pkg::cmd_t    q_head,
  output logic               q_pop,
  output logic               busy,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [shxfr_pkg::IDX_W-1:0] FB_LAST = shxfr_pkg::IDX_W'(FRAME_BYTES - 1);

  logic [7:0]                  mem [FRAME_BYTES];
  logic [7:0]                  rd_data;
  logic [AW-1:0]               rd_addr;
  shxfr_pkg::back_state_t      st, st_next;
  logic [shxfr_pkg::IDX_W-1:0] idx, idx_next;
  logic [31:0]                 yaw;
  logic                        out_free;
  logic                        load;
  shxfr_pkg::kind_t            o_kind;
  logic [7:0]                  o_data;
  logic [shxfr_pkg::IDX_W-1:0] o_pos;
  logic                        o_last;

  assign out_free = !m_tvalid || m_tready;
  assign busy     = !q_empty || (st != shxfr_pkg::BK_IDLE);

  always_comb begin
    st_next = st;
    idx_next = idx;
    load     = 1'b0;
    q_pop    = 1'b0;
    o_kind   = shxfr_pkg::KIND_MISMATCH;
    o_data   = '0;
    o_pos    = '0;
    o_last   = 1'b1;
    case (st)
      shxfr_pkg::BK_IDLE: begin
        if (!q_empty && (q_head.good || out_free)) begin
          q_pop = 1'b1;
          if (q_head.good) begin
            st_next  = shxfr_pkg::BK_PAY;
            idx_next = '0;
          end else begin
            load = 1'b1;
          end
        end
      end
      shxfr_pkg::BK_PAY: begin
        if (out_free) begin
          load   = 1'b1;
          o_kind = shxfr_pkg::KIND_PAYLOAD;
          o_data = rd_data;
          o_pos  = idx;
          o_last = 1'b0;
          if (idx == FB_LAST) begin
            st_next  = shxfr_pkg::BK_REPLY;
            idx_next = '0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      shxfr_pkg::BK_REPLY: begin
        if (out_free) begin
          load   = 1'b1;
          o_kind = shxfr_pkg::KIND_REPLY;
          o_data = shxfr_pkg::reply_byte(yaw, idx[2:0]);
          o_pos  = idx;
          o_last = (idx[2:0] == shxfr_pkg::REPLY_LAST);
          if (o_last) begin
            st_next  = shxfr_pkg::BK_IDLE;
            idx_next = '0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        st_next  = shxfr_pkg::BK_IDLE;
        idx_next = '0;
      end
    endcase
  end

  // The read address runs one step ahead so that rd_data holds the byte
  // for the current index.
  assign rd_addr = (st_next == shxfr_pkg::BK_PAY) ? idx_next[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (pl_wr.en) mem[pl_wr.idx[AW-1:0]] <= pl_wr.data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) yaw <= q_head.yaw;
    if (load) begin
      m_tdata <= {2'b00, o_pos, o_data};
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= shxfr_pkg::BK_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
